// File: rtl/fastcgi_record_params_parser_core_defines.svh
// Assertion macros shared by the checker of the FastCGI record parser.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef FASTCGI_RECORD_PARAMS_PARSER_CORE_DEFINES_SVH
`define FASTCGI_RECORD_PARAMS_PARSER_CORE_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define FCGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define FCGI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fcgi_pkg.sv
// Types and constants of the FastCGI record and PARAMS pair parser.
// No dependencies; every module file imports this package.
package fcgi_pkg;

  // Input beat: one byte of the record stream.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } fcgi_in_t;

  // Output beat: the byte with its tag and the current record context.
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic [7:0]  record_kind;
    logic [15:0] request_number;
    logic [15:0] content_bytes;
    logic [15:0] pair_number;
    logic [30:0] name_length;
    logic [30:0] value_length;
    logic        pair_last;
    logic        record_last;
    logic        pair_overrun;
  } fcgi_out_t;

  // Parser phase, one-hot.
  typedef enum logic [6:0] {
    PH_HEADER     = 7'b0000001,
    PH_NAME_LEN   = 7'b0000010,
    PH_VALUE_LEN  = 7'b0000100,
    PH_NAME_DATA  = 7'b0001000,
    PH_VALUE_DATA = 7'b0010000,
    PH_OTHER      = 7'b0100000,
    PH_PADDING    = 7'b1000000
  } phase_t;

  // Byte role codes on the result.
  localparam logic [2:0] ROLE_HEADER     = 3'd0;
  localparam logic [2:0] ROLE_NAME_LEN   = 3'd1;
  localparam logic [2:0] ROLE_VALUE_LEN  = 3'd2;
  localparam logic [2:0] ROLE_NAME_DATA  = 3'd3;
  localparam logic [2:0] ROLE_VALUE_DATA = 3'd4;
  localparam logic [2:0] ROLE_OTHER      = 3'd5;
  localparam logic [2:0] ROLE_PADDING    = 3'd6;

  // Byte offsets within the 8-byte record header.
  localparam logic [2:0] HDR_VERSION  = 3'd0;
  localparam logic [2:0] HDR_TYPE     = 3'd1;
  localparam logic [2:0] HDR_REQ_HI   = 3'd2;
  localparam logic [2:0] HDR_REQ_LO   = 3'd3;
  localparam logic [2:0] HDR_LEN_HI   = 3'd4;
  localparam logic [2:0] HDR_LEN_LO   = 3'd5;
  localparam logic [2:0] HDR_PAD      = 3'd6;
  localparam logic [2:0] HDR_RESERVED = 3'd7;

  // Record type that carries name-value pairs.
  localparam logic [7:0] PARAMS_KIND = 8'd4;

  // Byte positions within a four-byte length field.
  localparam logic [1:0] LEN_POS_FIRST = 2'd0;
  localparam logic [1:0] LEN_POS_B2    = 2'd1;
  localparam logic [1:0] LEN_POS_B1    = 2'd2;
  localparam logic [1:0] LEN_POS_LAST  = 2'd3;

  // Pair counter saturation value.
  localparam logic [15:0] PAIR_MAX = 16'hffff;

  // Result of taking one byte of a length field.
  typedef struct packed {
    logic [30:0] value;
    logic [1:0]  pos;
    logic        done;
  } len_step_t;

endpackage

// File: rtl/fastcgi_record_params_parser_core.sv
// Top level of the FastCGI record and PARAMS pair parser.
// Depends on fcgi_pkg, fcgi_in_stage, fcgi_step and fcgi_out_stage.

// The block takes one byte of a FastCGI record stream per beat and returns
// one result beat per byte: the byte itself, its role (header, length,
// name or value data, other content, padding), the current header fields,
// the decoded pair lengths, the pair count, and end-of-pair, end-of-record
// and overrun flags. It takes one byte every clock cycle while the result
// port is not stalled. A byte passes from the input register through the
// decode logic into the result register, from which its result is shown
// on the result port. A byte with restart set discards all parser state
// and is read as header byte 0.
module fastcgi_record_params_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  fcgi_pkg::fcgi_in_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output fcgi_pkg::fcgi_out_t result
);
  import fcgi_pkg::*;

  logic      held_valid;
  fcgi_in_t  held;
  logic      load_ready;
  logic      step_en;
  fcgi_out_t step_out;

  // A byte is decoded when the result register can take its beat.
  assign step_en = held_valid && load_ready;

  fcgi_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .held_valid (held_valid),
    .held       (held),
    .take       (step_en)
  );

  fcgi_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .din     (held),
    .dout    (step_out)
  );

  fcgi_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (held_valid),
    .load_ready   (load_ready),
    .load         (step_out),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: rtl/fcgi_in_stage.sv
// Input register of the FastCGI parser: holds one accepted byte beat.
// Depends on fcgi_pkg.
module fcgi_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  fcgi_pkg::fcgi_in_t item,
  output logic             held_valid,
  output fcgi_pkg::fcgi_in_t held,
  input  logic             take
);
  import fcgi_pkg::*;

  // The register frees up in the same cycle that the parser takes its beat.
  assign item_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

// File: rtl/fcgi_step.sv
// Parser state and the per-byte decode: header fields, pair lengths, data
// walk and pair counting. Depends on fcgi_pkg.
module fcgi_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  fcgi_pkg::fcgi_in_t  din,
  output fcgi_pkg::fcgi_out_t dout
);
  import fcgi_pkg::*;

  // Stored parser state.
  phase_t      phase;
  logic [2:0]  hpos;
  logic [7:0]  kind;
  logic [15:0] request;
  logic [15:0] content;
  logic [15:0] content_left;
  logic [7:0]  pad_left;
  logic [1:0]  len_pos;
  logic [30:0] name_len;
  logic [30:0] value_len;
  logic [30:0] data_left;
  logic [15:0] pair_count;

  phase_t      phase_next;
  logic [2:0]  hpos_next;
  logic [7:0]  kind_next;
  logic [15:0] request_next;
  logic [15:0] content_next;
  logic [15:0] content_left_next;
  logic [7:0]  pad_left_next;
  logic [1:0]  len_pos_next;
  logic [30:0] name_len_next;
  logic [30:0] value_len_next;
  logic [30:0] data_left_next;
  logic [15:0] pair_count_next;

  // Per-byte results.
  logic [15:0] pairs_before;
  logic [15:0] remain;
  logic [31:0] len_sum;
  len_step_t   len_res;
  logic [2:0]  role;
  logic        pair_flag;
  logic        overrun;
  logic        rec_last;

  // One byte of a length field: a short form below 0x80, or four bytes
  // with the top bit of the first one masked off.
  function automatic len_step_t len_step(input logic [30:0] acc, input logic [7:0] b,
                                         input logic [1:0] pos);
    len_step_t r;
    r.value = acc;
    r.pos   = pos;
    r.done  = 1'b0;
    if (pos == LEN_POS_FIRST) begin
      if (!b[7]) begin
        r.value = {23'd0, b};
        r.done  = 1'b1;
      end else begin
        r.value = {b[6:0], 24'd0};
        r.pos   = LEN_POS_B2;
      end
    end else begin
      case (pos)
        LEN_POS_B2: r.value = acc | {7'd0, b, 16'd0};
        LEN_POS_B1: r.value = acc | {15'd0, b, 8'd0};
        default:    r.value = acc | {23'd0, b};
      endcase
      r.pos  = pos + 2'd1;
      r.done = (pos == LEN_POS_LAST);
    end
    return r;
  endfunction

  always_comb begin
    // Start from the stored state, or from the reset state on a restart beat.
    if (din.restart) begin
      phase_next        = PH_HEADER;
      hpos_next         = HDR_VERSION;
      kind_next         = '0;
      request_next      = '0;
      content_next      = '0;
      content_left_next = '0;
      pad_left_next     = '0;
      len_pos_next      = LEN_POS_FIRST;
      name_len_next     = '0;
      value_len_next    = '0;
      data_left_next    = '0;
      pair_count_next   = '0;
    end else begin
      phase_next        = phase;
      hpos_next         = hpos;
      kind_next         = kind;
      request_next      = request;
      content_next      = content;
      content_left_next = content_left;
      pad_left_next     = pad_left;
      len_pos_next      = len_pos;
      name_len_next     = name_len;
      value_len_next    = value_len;
      data_left_next    = data_left;
      pair_count_next   = pair_count;
    end

    // The first header byte opens a fresh record context.
    if (phase_next == PH_HEADER && hpos_next == HDR_VERSION) begin
      kind_next       = '0;
      request_next    = '0;
      content_next    = '0;
      pair_count_next = '0;
      name_len_next   = '0;
      value_len_next  = '0;
    end
    pairs_before = pair_count_next;

    pair_flag = 1'b0;
    overrun   = 1'b0;
    rec_last  = 1'b0;
    role      = ROLE_HEADER;
    remain    = '0;
    len_sum   = '0;
    len_res   = '0;

    case (phase_next)
      PH_PADDING: begin
        role = ROLE_PADDING;
        if (pad_left_next != 8'd0) begin
          pad_left_next = pad_left_next - 8'd1;
        end
        if (pad_left_next == 8'd0) begin
          rec_last   = 1'b1;
          phase_next = PH_HEADER;
          hpos_next  = HDR_VERSION;
        end
      end

      PH_NAME_LEN, PH_VALUE_LEN, PH_NAME_DATA, PH_VALUE_DATA, PH_OTHER: begin
        remain = (content_left_next != 16'd0) ? content_left_next - 16'd1 : 16'd0;
        case (phase_next)
          PH_NAME_LEN: begin
            role = ROLE_NAME_LEN;
            if (len_pos_next == LEN_POS_FIRST) begin
              value_len_next = '0;
            end
            len_res       = len_step(name_len_next, din.rx_byte, len_pos_next);
            name_len_next = len_res.value;
            len_pos_next  = len_res.pos;
            if (len_res.done) begin
              phase_next = PH_VALUE_LEN;
            end
          end
          PH_VALUE_LEN: begin
            role           = ROLE_VALUE_LEN;
            len_res        = len_step(value_len_next, din.rx_byte, len_pos_next);
            value_len_next = len_res.value;
            len_pos_next   = len_res.pos;
            if (len_res.done) begin
              // Check that the whole pair fits in the content left.
              len_sum = {1'b0, name_len_next} + {1'b0, value_len_next};
              if (len_sum > {16'd0, remain}) begin
                overrun = 1'b1;
              end
              if (name_len_next != 31'd0) begin
                phase_next     = PH_NAME_DATA;
                data_left_next = name_len_next;
              end else if (value_len_next != 31'd0) begin
                phase_next     = PH_VALUE_DATA;
                data_left_next = value_len_next;
              end else begin
                pair_flag    = 1'b1;
                phase_next   = PH_NAME_LEN;
                len_pos_next = LEN_POS_FIRST;
              end
            end
          end
          PH_NAME_DATA: begin
            role = ROLE_NAME_DATA;
            if (data_left_next != 31'd0) begin
              data_left_next = data_left_next - 31'd1;
            end
            if (data_left_next == 31'd0) begin
              if (value_len_next != 31'd0) begin
                phase_next     = PH_VALUE_DATA;
                data_left_next = value_len_next;
              end else begin
                pair_flag    = 1'b1;
                phase_next   = PH_NAME_LEN;
                len_pos_next = LEN_POS_FIRST;
              end
            end
          end
          PH_VALUE_DATA: begin
            role = ROLE_VALUE_DATA;
            if (data_left_next != 31'd0) begin
              data_left_next = data_left_next - 31'd1;
            end
            if (data_left_next == 31'd0) begin
              pair_flag    = 1'b1;
              phase_next   = PH_NAME_LEN;
              len_pos_next = LEN_POS_FIRST;
            end
          end
          default: begin
            role = ROLE_OTHER;
          end
        endcase

        // End of content: a pair cut short is closed and flagged, then on
        // to the padding or the next header.
        content_left_next = remain;
        if (remain == 16'd0) begin
          if (role != ROLE_OTHER && !pair_flag &&
              (phase_next != PH_NAME_LEN || len_pos_next != LEN_POS_FIRST)) begin
            pair_flag = 1'b1;
            overrun   = 1'b1;
          end
          len_pos_next   = LEN_POS_FIRST;
          data_left_next = '0;
          hpos_next      = HDR_VERSION;
          if (pad_left_next != 8'd0) begin
            phase_next = PH_PADDING;
          end else begin
            phase_next = PH_HEADER;
            rec_last   = 1'b1;
          end
        end
      end

      default: begin
        // Header bytes; any stray phase code is read as a header too.
        role       = ROLE_HEADER;
        phase_next = PH_HEADER;
        case (hpos_next)
          HDR_TYPE:   kind_next = din.rx_byte;
          HDR_REQ_HI: request_next = {din.rx_byte, 8'd0};
          HDR_REQ_LO: request_next = request_next | {8'd0, din.rx_byte};
          HDR_LEN_HI: content_next = {din.rx_byte, 8'd0};
          HDR_LEN_LO: content_next = content_next | {8'd0, din.rx_byte};
          HDR_PAD:    pad_left_next = din.rx_byte;
          HDR_RESERVED: begin
            content_left_next = content_next;
            len_pos_next      = LEN_POS_FIRST;
            data_left_next    = '0;
            if (content_next != 16'd0) begin
              phase_next = (kind_next == PARAMS_KIND) ? PH_NAME_LEN : PH_OTHER;
            end else if (pad_left_next != 8'd0) begin
              phase_next = PH_PADDING;
            end else begin
              rec_last = 1'b1;
            end
          end
          default: begin
          end
        endcase
        hpos_next = hpos_next + 3'd1;
      end
    endcase

    // Count the completed pair, saturating.
    if (pair_flag && pair_count_next != PAIR_MAX) begin
      pair_count_next = pair_count_next + 16'd1;
    end
  end

  // Result beat for the byte in the input register.
  always_comb begin
    dout.byte_out       = din.rx_byte;
    dout.byte_role      = role;
    dout.record_kind    = kind_next;
    dout.request_number = request_next;
    dout.content_bytes  = content_next;
    dout.pair_number    = pairs_before;
    dout.name_length    = name_len_next;
    dout.value_length   = value_len_next;
    dout.pair_last      = pair_flag;
    dout.record_last    = rec_last;
    dout.pair_overrun   = overrun;
  end

  // State update, once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hpos         <= HDR_VERSION;
      kind         <= '0;
      request      <= '0;
      content      <= '0;
      content_left <= '0;
      pad_left     <= '0;
      len_pos      <= LEN_POS_FIRST;
      name_len     <= '0;
      value_len    <= '0;
      data_left    <= '0;
      pair_count   <= '0;
    end else if (step_en) begin
      phase        <= phase_next;
      hpos         <= hpos_next;
      kind         <= kind_next;
      request      <= request_next;
      content      <= content_next;
      content_left <= content_left_next;
      pad_left     <= pad_left_next;
      len_pos      <= len_pos_next;
      name_len     <= name_len_next;
      value_len    <= value_len_next;
      data_left    <= data_left_next;
      pair_count   <= pair_count_next;
    end
  end

endmodule

// File: rtl/fcgi_out_stage.sv
// Output register of the FastCGI parser: holds one result beat until taken.
// Depends on fcgi_pkg.
module fcgi_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  fcgi_pkg::fcgi_out_t load,
  output logic                result_valid,
  input  logic                result_ready,
  output fcgi_pkg::fcgi_out_t result
);
  import fcgi_pkg::*;

  // A new beat may load while the current one leaves.
  assign load_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ready) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      result <= load;
    end
  end

endmodule

// File: rtl/fcgi_checker.sv
// Port-level checks of the FastCGI parser, bound to the top level.
// Depends on fcgi_pkg and fastcgi_record_params_parser_core_defines.svh.
`include "fastcgi_record_params_parser_core_defines.svh"

module fcgi_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input fcgi_pkg::fcgi_out_t result
);
  import fcgi_pkg::*;

  logic stalled;
  logic pair_byte;
  logic overrun_byte;
  logic header_end_ok;

  // Conditions on the result beat that the assertions below use.
  assign stalled      = result_valid && !result_ready;
  assign pair_byte    = (result.byte_role != ROLE_HEADER) &&
                        (result.byte_role != ROLE_OTHER) &&
                        (result.byte_role != ROLE_PADDING);
  assign overrun_byte = result.pair_last || (result.byte_role == ROLE_VALUE_LEN);
  assign header_end_ok = !(result.record_last && result.byte_role == ROLE_HEADER) ||
                         (result.content_bytes == 16'd0);

  // Reset empties the result register.
  `FCGI_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // A stalled result beat holds.
  `FCGI_ASSERT(a_result_hold, stalled |=> result_valid && $stable(result), "stalled result changed")

  // Only length or data bytes can complete a pair.
  `FCGI_ASSERT(a_pair_role, result_valid && result.pair_last |-> pair_byte, "pair end off a pair")

  // Overrun is flagged on a value length byte or on a forced pair close.
  `FCGI_ASSERT(a_overrun_place, result_valid && result.pair_overrun |-> overrun_byte, "bad overrun")

  // A header byte can end a record only when the record has no content.
  `FCGI_ASSERT(a_empty_record, result_valid |-> header_end_ok, "header ended a record with content")

endmodule

bind fastcgi_record_params_parser_core fcgi_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
